@@ sv/ypmv_pkg.sv @@
`default_nettype none
package ypmv_pkg;

	// dimensions and field widths
	localparam int MAX_DIMENSION = 4096;
	localparam int MIN_DIMENSION = 2;
	localparam int DIM_W         = 13;
	localparam int DIM_CL_W      = $clog2(MAX_DIMENSION + 1);
	localparam int PIX_W         = 8;
	localparam int FRAC_BITS     = 8;
	localparam int FRAME_W       = 16;
	localparam int PLANE_W       = 2;
	localparam int MEAN_W        = 16;
	localparam int VAR_W         = 22;
	localparam int CFG_IDX_W     = 1;

	// accumulator and arithmetic widths
	localparam int CNT_W     = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
	localparam int LUMA_W    = 2 * DIM_CL_W;
	localparam int SUM_W     = PIX_W + CNT_W - 1;
	localparam int SQ_W      = 2 * PIX_W + CNT_W - 1;
	localparam int QH_W      = SQ_W + 1;
	localparam int MUL_SPLIT = 24;
	localparam int X_W       = CNT_W + QH_W;
	// n*(q+h) - s*s is below n*n times (max variance + 1)
	localparam int X_RES_W   = 2 * (CNT_W - 1) + 2 * PIX_W - 2;
	localparam int DIV_W     = X_RES_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(1920);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(1080);
	localparam logic [VAR_W-1:0]  VAR_MAX      = VAR_W'(4194303);
	localparam logic [MEAN_W-1:0] MEAN_MAX     = MEAN_W'(255 * 256);

	localparam logic [PLANE_W-1:0] PLANE_Y = PLANE_W'(0);
	localparam logic [PLANE_W-1:0] PLANE_U = PLANE_W'(1);
	localparam logic [PLANE_W-1:0] PLANE_V = PLANE_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SQR,
		ST_DIV_MEAN,
		ST_DIV_VA,
		ST_DIV_VB,
		ST_EMIT
	} ypmv_state_t;

	typedef enum logic [1:0] {
		DIV_SRC_MEAN,
		DIV_SRC_VA,
		DIV_SRC_VB
	} div_src_t;

	typedef struct packed {
		logic     acc_en;
		logic     snap;
		logic     mul_lo;
		logic     mul_hi;
		logic     x_sub;
		logic     div_load;
		div_src_t div_sel;
		logic     div_step;
		logic     mean_cap;
		logic     var_cap;
		logic     out_load;
	} ypmv_cmd_t;

	typedef struct packed {
		logic plane_end;
		logic div_done;
		logic out_free;
	} ypmv_sts_t;

endpackage
`default_nettype wire

@@ sv/ypmv_ctrl.sv @@
`default_nettype none
module ypmv_ctrl import ypmv_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      pixel_valid,
	input  wire ypmv_sts_t sts,
	output logic           pixel_ready,
	output ypmv_cmd_t      cmd
);

	ypmv_state_t state_q;
	ypmv_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (pixel_valid && sts.plane_end)
					state_d = ST_MUL_LO;
			end
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_SQR;
			ST_SQR:      state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (sts.div_done)
					state_d = ST_DIV_VA;
			end
			ST_DIV_VA: begin
				if (sts.div_done)
					state_d = ST_DIV_VB;
			end
			ST_DIV_VB: begin
				if (sts.div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free)
					state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.div_sel = DIV_SRC_MEAN;
		pixel_ready = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				pixel_ready = 1'b1;
				cmd.acc_en  = pixel_valid;
				cmd.snap    = pixel_valid && sts.plane_end;
			end
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_SQR: begin
				cmd.x_sub    = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_SRC_MEAN;
			end
			ST_DIV_MEAN: begin
				cmd.div_step = 1'b1;
				cmd.mean_cap = sts.div_done;
				cmd.div_load = sts.div_done;
				cmd.div_sel  = DIV_SRC_VA;
			end
			ST_DIV_VA: begin
				cmd.div_step = 1'b1;
				cmd.div_load = sts.div_done;
				cmd.div_sel  = DIV_SRC_VB;
			end
			ST_DIV_VB: begin
				cmd.div_step = 1'b1;
				cmd.var_cap  = sts.div_done;
			end
			ST_EMIT: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	a_leave_accum_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCUM && state_d != ST_ACCUM) |-> (pixel_valid && sts.plane_end))
		else $error("left accumulation without a plane end");

	a_capture_on_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mean_cap || cmd.var_cap) |-> (sts.div_done && cmd.div_step))
		else $error("quotient captured before the last divider step");

	a_snap_starts_math: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> (state_q == ST_MUL_LO))
		else $error("plane end did not start the result sequence");

endmodule
`default_nettype wire

@@ sv/ypmv_dp.sv @@
`default_nettype none
module ypmv_dp import ypmv_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [PIX_W-1:0]     pixel_value,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire ypmv_cmd_t            cmd,
	input  wire logic                 result_ready,
	output ypmv_sts_t                 sts,
	output logic                      result_valid,
	output logic [FRAME_W-1:0]        frame_index,
	output logic [PLANE_W-1:0]        plane_index,
	output logic [MEAN_W-1:0]         plane_mean,
	output logic [VAR_W-1:0]          plane_variance
);

	localparam int PLO_W = CNT_W + MUL_SPLIT;
	localparam int PHI_W = CNT_W + QH_W - MUL_SPLIT;

	function automatic logic [DIM_CL_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_CL_W-1:0] r;
		if (32'(d) < 32'(MIN_DIMENSION))
			r = DIM_CL_W'(MIN_DIMENSION);
		else if (32'(d) > 32'(MAX_DIMENSION))
			r = DIM_CL_W'(MAX_DIMENSION);
		else
			r = DIM_CL_W'(d);
		return r;
	endfunction

	// configuration and running state
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     s_acc_q;
	logic [SQ_W-1:0]      q_acc_q;
	logic [PLANE_W-1:0]   plane_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	// plane snapshot and arithmetic registers
	logic [CNT_W-1:0]     n_q;
	logic [SUM_W-1:0]     s_q;
	logic [SQ_W-1:0]      q_q;
	logic [FRAME_W-1:0]   snap_frame_q;
	logic [PLANE_W-1:0]   snap_plane_q;
	logic [X_W-1:0]       x_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [CNT_W-1:0]     rem_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [VAR_W-1:0]     var_q;
	logic [FRAME_W-1:0]   out_frame_q;
	logic [PLANE_W-1:0]   out_plane_q;
	logic [MEAN_W-1:0]    out_mean_q;
	logic [VAR_W-1:0]     out_var_q;

	// plane length and accumulation
	logic [LUMA_W-1:0]    luma_len;
	logic [LUMA_W-1:0]    plane_len;
	logic [CNT_W-1:0]     cnt_inc;
	logic [2*PIX_W-1:0]   px_sq;
	logic [SUM_W-1:0]     s_next;
	logic [SQ_W-1:0]      q_next;

	assign luma_len  = clamp_dim(width_q) * clamp_dim(height_q);
	assign plane_len = (plane_q == PLANE_Y) ? luma_len : (luma_len >> 2);
	assign cnt_inc   = cnt_q + 1'b1;
	assign px_sq     = pixel_value * pixel_value;
	assign s_next    = s_acc_q + SUM_W'(pixel_value);
	assign q_next    = q_acc_q + SQ_W'(px_sq);

	// n*(q + n/2) in two partial products, then minus s*s
	logic [QH_W-1:0]      qh;
	logic [PLO_W-1:0]     prod_lo;
	logic [PHI_W-1:0]     prod_hi;
	logic [2*SUM_W-1:0]   sqr;

	assign qh      = QH_W'(q_q) + QH_W'(n_q >> 1);
	assign prod_lo = n_q * qh[MUL_SPLIT-1:0];
	assign prod_hi = n_q * qh[QH_W-1:MUL_SPLIT];
	assign sqr     = s_q * s_q;

	// restoring divider, one quotient bit per step
	logic [CNT_W:0]       div_trial;
	logic                 div_ge;
	logic [CNT_W-1:0]     div_rem_nx;
	logic [DIV_W-1:0]     div_quo_nx;
	logic [DIV_W-1:0]     div_load_val;
	logic [VAR_W-1:0]     var_sat;

	assign div_trial  = {rem_q, dvd_q[DIV_W-1]};
	assign div_ge     = div_trial >= {1'b0, n_q};
	assign div_rem_nx = div_ge ? CNT_W'(div_trial - {1'b0, n_q}) : div_trial[CNT_W-1:0];
	assign div_quo_nx = {dvd_q[DIV_W-2:0], div_ge};
	assign var_sat    = (div_quo_nx > DIV_W'(VAR_MAX)) ? VAR_MAX : div_quo_nx[VAR_W-1:0];

	always_comb begin
		case (cmd.div_sel)
			DIV_SRC_MEAN: div_load_val = DIV_W'({s_q, {FRAC_BITS{1'b0}}});
			DIV_SRC_VA:   div_load_val = {x_q[X_RES_W-1:0], {FRAC_BITS{1'b0}}};
			DIV_SRC_VB:   div_load_val = div_quo_nx;
			default:      div_load_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
			cnt_q       <= '0;
			s_acc_q     <= '0;
			q_acc_q     <= '0;
			plane_q     <= PLANE_Y;
			frame_q     <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_FRAME_WIDTH:  width_q  <= cfg_data;
					CFG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc_en) begin
				if (cmd.snap) begin
					cnt_q   <= '0;
					s_acc_q <= '0;
					q_acc_q <= '0;
					if (plane_q >= PLANE_V) begin
						plane_q <= PLANE_Y;
						frame_q <= frame_q + 1'b1;
					end else begin
						plane_q <= plane_q + 1'b1;
					end
				end else begin
					cnt_q   <= cnt_inc;
					s_acc_q <= s_next;
					q_acc_q <= q_next;
				end
			end
			if (cmd.div_load)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			n_q          <= cnt_inc;
			s_q          <= s_next;
			q_q          <= q_next;
			snap_frame_q <= frame_q;
			snap_plane_q <= plane_q;
		end
		if (cmd.mul_lo)
			x_q <= X_W'(prod_lo);
		else if (cmd.mul_hi)
			x_q <= x_q + (X_W'(prod_hi) << MUL_SPLIT);
		else if (cmd.x_sub)
			x_q <= x_q - X_W'(sqr);
		if (cmd.div_load) begin
			dvd_q <= div_load_val;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= div_quo_nx;
			rem_q <= div_rem_nx;
		end
		if (cmd.mean_cap)
			mean_q <= div_quo_nx[MEAN_W-1:0];
		if (cmd.var_cap)
			var_q <= var_sat;
		if (cmd.out_load) begin
			out_frame_q <= snap_frame_q;
			out_plane_q <= snap_plane_q;
			out_mean_q  <= mean_q;
			out_var_q   <= var_q;
		end
	end

	assign sts.plane_end = LUMA_W'(cnt_inc) >= plane_len;
	assign sts.div_done  = div_cnt_q == DIV_CNT_W'(DIV_W - 1);
	assign sts.out_free  = !out_valid_q || result_ready;

	assign result_valid   = out_valid_q;
	assign frame_index    = out_frame_q;
	assign plane_index    = out_plane_q;
	assign plane_mean     = out_mean_q;
	assign plane_variance = out_var_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < n_q))
		else $error("divider remainder not below the pixel count");

	a_spread_fits: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.x_sub) |-> (x_q[X_W-1:X_RES_W] == '0))
		else $error("n*q - s*s exceeds its bound");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (mean_q <= MEAN_MAX))
		else $error("mean above the largest sample value");

endmodule
`default_nettype wire

@@ sv/yuv_plane_mean_variance_unit.sv @@
`default_nettype none
// channel   | signals                                          | transaction
// ----------+--------------------------------------------------+-----------------------------
// pixel     | pixel_valid, pixel_ready, pixel_value            | one 8-bit sample, planar order
// result    | result_valid, result_ready, frame_index,         | one per finished plane
//           | plane_index, plane_mean, plane_variance          |
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data        | 0 frame_width, 1 frame_height
//
// samples are taken at one per cycle while a plane is being accumulated
// the last sample of a plane holds the pixel channel off while the block forms the two partial
// products and subtracts s*s, runs three passes of the bit-serial divider and loads the result register;
// longer if the previous result has not been taken yet
// a waiting result does not block sample intake for the next plane
// arst_n clears counters, accumulators, plane/frame indexes and sets 1920x1080
// cfg_ready is always high; dimensions are clamped to 2..4096 on use
module yuv_plane_mean_variance_unit import ypmv_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pixel_valid,
	output logic                      pixel_ready,
	input  wire logic [PIX_W-1:0]     pixel_value,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [FRAME_W-1:0]        frame_index,
	output logic [PLANE_W-1:0]        plane_index,
	output logic [MEAN_W-1:0]         plane_mean,
	output logic [VAR_W-1:0]          plane_variance,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	ypmv_cmd_t cmd;
	ypmv_sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencer: accumulate, multiply, three divisions, hand off the result
	ypmv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.sts         (sts),
		.pixel_ready (pixel_ready),
		.cmd         (cmd)
	);

	// accumulators, plane length, multiplier, divider and result register
	ypmv_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_value    (pixel_value),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.result_ready   (result_ready),
		.sts            (sts),
		.result_valid   (result_valid),
		.frame_index    (frame_index),
		.plane_index    (plane_index),
		.plane_mean     (plane_mean),
		.plane_variance (plane_variance)
	);

endmodule
`default_nettype wire

@@ sim/tb_yuv_plane_mean_variance_unit.sv @@
`timescale 1ns / 100ps

module tb_yuv_plane_mean_variance_unit import ypmv_pkg::*;;

	localparam int IDLE_PERCENT   = 36;
	localparam int HOLD_CYCLES    = 700;   // long result-side stall, fills the block
	localparam int SETTLE_CYCLES  = 240;   // covers the plane-end result sequence plus margin
	localparam int STALL_LIMIT    = 6000;  // cycles without any transaction
	localparam int RANDOM_SAMPLES = 1950;

	// one finished-plane record as it leaves the block
	typedef struct {
		logic [FRAME_W-1:0] frame;
		logic [PLANE_W-1:0] plane;
		logic [MEAN_W-1:0]  mean;
		logic [VAR_W-1:0]   variance;
	} plane_stats_t;

	typedef struct {
		cfg_reg_t           index;
		logic [DIM_W-1:0]   data;
	} geometry_write_t;

	// dut ports, all inputs known from time zero
	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 pixel_valid    = 1'b0;
	logic                 pixel_ready;
	logic [PIX_W-1:0]     pixel_value    = '0;
	logic                 result_valid;
	logic                 result_ready   = 1'b0;
	logic [FRAME_W-1:0]   frame_index;
	logic [PLANE_W-1:0]   plane_index;
	logic [MEAN_W-1:0]    plane_mean;
	logic [VAR_W-1:0]     plane_variance;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index      = CFG_FRAME_WIDTH;
	logic [DIM_W-1:0]     cfg_data       = '0;

	// stimulus queues and the store of expected plane statistics
	logic [PIX_W-1:0]     pixel_pending[$];
	geometry_write_t      geometry_pending[$];
	plane_stats_t         plane_stats_expected[$];

	// predictor copy of the block: geometry registers and plane accumulators
	logic [DIM_W-1:0]     width_setting  = WIDTH_RESET;
	logic [DIM_W-1:0]     height_setting = HEIGHT_RESET;
	longint unsigned      sample_count   = 0;
	longint unsigned      sample_sum     = 0;
	longint unsigned      square_sum     = 0;
	logic [PLANE_W-1:0]   plane_now      = PLANE_Y;
	logic [FRAME_W-1:0]   frame_now      = '0;

	// traffic shaping shared by the drivers
	logic                 steady_mode    = 1'b0;
	int                   hold_requests  = 0;
	int                   holds_started  = 0;
	int                   hold_left      = 0;
	int                   idle_cycles    = 0;
	int                   error_count    = 0;

	yuv_plane_mean_variance_unit i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// dimensions are saturated to 2..MAX_DIMENSION before use
	function automatic longint unsigned clamp_dimension(logic [DIM_W-1:0] d);
		if (d < MIN_DIMENSION)
			return MIN_DIMENSION;
		if (d > MAX_DIMENSION)
			return MAX_DIMENSION;
		return d;
	endfunction

	// add one sample; on the last sample of a plane queue its statistics
	task automatic accumulate_sample(input logic [PIX_W-1:0] px);
		longint unsigned luma;
		longint unsigned span;
		logic [127:0]    spread;
		logic [127:0]    var_wide;
		plane_stats_t    stats;

		// plane length follows the current registers on every sample
		luma = clamp_dimension(width_setting) * clamp_dimension(height_setting);
		span = (plane_now == PLANE_Y) ? luma : luma / 4;
		sample_sum   += px;
		square_sum   += longint'(px) * px;
		sample_count += 1;
		if (sample_count < span)
			return;

		stats.frame = frame_now;
		stats.plane = plane_now;
		stats.mean  = MEAN_W'((sample_sum << FRAC_BITS) / sample_count);
		// 256*(Q - S*S/N + N/2)/N == 256*(N*(Q + N/2) - S*S) / N^2, kept exact
		spread = 128'(sample_count) * (128'(square_sum) + 128'(sample_count / 2))
			- 128'(sample_sum) * 128'(sample_sum);
		var_wide = (spread << FRAC_BITS) / (128'(sample_count) * 128'(sample_count));
		stats.variance = (var_wide > 128'(VAR_MAX)) ? VAR_MAX : VAR_W'(var_wide);
		plane_stats_expected.push_back(stats);

		sample_count = 0;
		sample_sum   = 0;
		square_sum   = 0;
		if (plane_now == PLANE_V) begin
			plane_now = PLANE_Y;
			frame_now = frame_now + 1'b1;
		end else begin
			plane_now = plane_now + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// drivers and monitor, all on the rising edge
	// ------------------------------------------------------------------

	// pixel driver: valid holds with a stable sample until the transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel_value <= '0;
		end else begin
			if (pixel_valid && pixel_ready)
				accumulate_sample(pixel_value);
			if (!pixel_valid || pixel_ready) begin
				if (pixel_pending.size() != 0
						&& (steady_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
					pixel_valid <= 1'b1;
					pixel_value <= pixel_pending.pop_front();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// geometry register driver, updates the predictor copy on each transaction
	always @(posedge clk or negedge arst_n) begin
		geometry_write_t wr;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= CFG_FRAME_WIDTH;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  width_setting  = cfg_data;
					CFG_FRAME_HEIGHT: height_setting = cfg_data;
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (geometry_pending.size() != 0
						&& (steady_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
					wr = geometry_pending.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= wr.index;
					cfg_data  <= wr.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest expectation, then pick next ready
	always @(posedge clk or negedge arst_n) begin
		plane_stats_t want;
		if (!arst_n) begin
			result_ready  <= 1'b0;
			hold_left     <= 0;
			holds_started <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (plane_stats_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result frame %0d plane %0d",
						frame_index, plane_index));
				end else begin
					want = plane_stats_expected.pop_front();
					if (frame_index !== want.frame)
						report_mismatch($sformatf("frame_index got %0d expected %0d",
							frame_index, want.frame));
					if (plane_index !== want.plane)
						report_mismatch($sformatf("plane_index got %0d expected %0d",
							plane_index, want.plane));
					if (plane_mean !== want.mean)
						report_mismatch($sformatf("plane_mean got %0d expected %0d",
							plane_mean, want.mean));
					if (plane_variance !== want.variance)
						report_mismatch($sformatf("plane_variance got %0d expected %0d",
							plane_variance, want.variance));
				end
			end
			// a requested hold-off keeps ready low for a long fixed stretch
			if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (holds_started != hold_requests) begin
				holds_started <= holds_started + 1;
				hold_left     <= HOLD_CYCLES;
				result_ready  <= 1'b0;
			end else begin
				result_ready <= steady_mode || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// watchdog on cycles where no channel completes a transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] timeout: no transaction for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencing, done on the falling edge so it never races the drivers
	// ------------------------------------------------------------------

	// block idle: no samples left, no result outstanding, divider finished
	task automatic wait_drained();
		while (pixel_pending.size() != 0 || pixel_valid || plane_stats_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_setting(input cfg_reg_t index, input int value);
		geometry_write_t wr;
		wr.index = index;
		wr.data  = DIM_W'(value);
		geometry_pending.push_back(wr);
		while (geometry_pending.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic write_geometry(input int width, input int height);
		write_setting(CFG_FRAME_WIDTH, width);
		write_setting(CFG_FRAME_HEIGHT, height);
	endtask

	// sample styles: uniform, black/white only, narrow band, flat
	function automatic logic [PIX_W-1:0] draw_sample(input int style, input logic [7:0] base);
		case (style)
			0:       return PIX_W'($urandom_range(255));
			1:       return $urandom_range(1) ? 8'hFF : 8'h00;
			2:       return base + PIX_W'($urandom_range(3));
			default: return base;
		endcase
	endfunction

	initial begin
		int              phase;
		int              count;
		int              style;
		int              width;
		int              height;
		int              random_sent;
		logic [PIX_W-1:0] base;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry is 1920x1080: these samples must not close the luma plane
		pixel_pending = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01};
		wait_drained();

		// out-of-range low dimensions saturate to 2x2 (luma 4, chroma 1)
		// five samples already taken, so the next one closes the luma plane
		write_geometry(0, 1);
		pixel_pending = '{8'd128, 8'hFF, 8'h00};
		// full white luma gives the top mean, with a variance of 128 from the n/2 rounding term
		pixel_pending = {pixel_pending, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
		wait_drained();

		// 3x2 with alternating black and white pushes the variance up
		write_geometry(3, 2);
		pixel_pending = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
		wait_drained();

		// out-of-range high dimensions saturate to 4096, then shrink mid-plane
		write_geometry(8191, 4097);
		repeat (6) pixel_pending.push_back(PIX_W'($urandom_range(255)));
		wait_drained();
		write_geometry(2, 2);
		pixel_pending.push_back(8'h7F);
		wait_drained();
		// same again inside a chroma plane, exact upper limit this time
		write_geometry(MAX_DIMENSION, MAX_DIMENSION);
		pixel_pending = '{8'h80, 8'h10, 8'hEF};
		wait_drained();
		write_geometry(2, 2);
		pixel_pending = '{8'h33, 8'hCC};
		wait_drained();

		// random phases: new geometry each time, planes often left unfinished
		phase       = 0;
		random_sent = 0;
		while (random_sent < RANDOM_SAMPLES) begin
			if (phase == 4 || phase == 9) begin
				// small planes so that two results pile up during the hold-off
				width  = $urandom_range(2, 6);
				height = $urandom_range(2, 6);
			end else if ($urandom_range(5) == 0) begin
				width  = $urandom_range(10, 20);
				height = $urandom_range(2, 12);
			end else begin
				width  = $urandom_range(0, 9);
				height = $urandom_range(0, 9);
			end
			write_geometry(width, height);
			style       = $urandom_range(3);
			base        = PIX_W'($urandom_range(252));
			steady_mode = (phase == 2);
			count       = $urandom_range(80, 200);
			if (count > RANDOM_SAMPLES - random_sent)
				count = RANDOM_SAMPLES - random_sent;
			for (int i = 0; i < count; i++)
				pixel_pending.push_back(draw_sample(style, base));
			// result side goes quiet while samples keep coming
			if (phase == 4 || phase == 9)
				hold_requests++;
			random_sent += count;
			phase++;
			wait_drained();
		end
		steady_mode = 1'b0;

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/ypmv_pkg.sv
sv/ypmv_ctrl.sv
sv/ypmv_dp.sv
sv/yuv_plane_mean_variance_unit.sv
sim/tb_yuv_plane_mean_variance_unit.sv
